// ===== design/tkm_pkg.sv =====
// Shared types, codes and the helper function of the timestamp k-way merge.
package tkm_pkg;

    localparam int LANE_W     = 4;
    localparam int TS_W       = 64;
    localparam int DIR_W      = 8;
    localparam int CNT_W      = 5;
    localparam int MAX_LANES  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int TDATA_W    = 80;

    // Command codes carried in the input tuser.
    localparam logic CMD_HEAD = 1'b0;
    localparam logic CMD_END  = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LANES_IN_USE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANES_PER_INPUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEDUP_ENABLE    = 2'd2;

    // Settings seen by the merge engine, already clamped.
    typedef struct packed {
        logic [CNT_W-1:0] lane_count;
        logic [CNT_W-1:0] slots;
        logic             dedup;
    } cfg_t;

    // One classified item waiting for the merge engine. An item whose lane is
    // out of use changes no lane but still starts a merge pass.
    typedef struct packed {
        logic              is_end;
        logic              in_use;
        logic [LANE_W-1:0] lane;
        logic [TS_W-1:0]   ts;
        logic [DIR_W-1:0]  dir;
        logic              known;
    } item_t;

    // A candidate head in the minimum search.
    typedef struct packed {
        logic              valid;
        logic [LANE_W-1:0] lane;
        logic [TS_W-1:0]   ts;
    } cand_t;

    // One emitted head.
    typedef struct packed {
        logic [LANE_W-1:0] lane;
        logic [TS_W-1:0]   ts;
        logic [DIR_W-1:0]  dir;
        logic              known;
    } res_t;

    // The lower lane is always passed as lo, so it wins on equal timestamps.
    function automatic cand_t cand_min(input cand_t lo, input cand_t hi);
        return (hi.valid && (!lo.valid || hi.ts < lo.ts)) ? hi : lo;
    endfunction

endpackage

// ===== design/tkm_queue.sv =====
// Small FIFO that holds classified items between the front end and the merge engine.
module tkm_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tkm_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output tkm_pkg::item_t  pop_item,
    output logic            not_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tkm_pkg::item_t   entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/tkm_front.sv =====
// Input side: unpacks each transfer, marks items for lanes out of use and queues them all.
module tkm_front (
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [tkm_pkg::TDATA_W-1:0]   s_axis_tdata,
    input  logic                          s_axis_tuser,
    input  tkm_pkg::cfg_t                 cfg,
    input  logic                          queue_full,
    output logic                          push,
    output tkm_pkg::item_t                push_item
);

    logic in_use;

    // Items for lanes at or above the lane count change no lane, but they
    // still let the merge engine emit whatever has become ready.
    assign in_use = ({1'b0, s_axis_tdata[3:0]} < cfg.lane_count);

    always_comb
    begin
        push_item.is_end = (s_axis_tuser == tkm_pkg::CMD_END);
        push_item.in_use = in_use;
        push_item.lane   = s_axis_tdata[3:0];
        push_item.ts     = s_axis_tdata[67:4];
        push_item.dir    = s_axis_tdata[75:68];
        push_item.known  = s_axis_tdata[76];
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

endmodule

// ===== design/tkm_back.sv =====
// Merge engine: holds one head per lane and emits them in timestamp order.
module tkm_back #(
    parameter int HEAD_DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tkm_pkg::cfg_t                 cfg,
    input  logic                          q_valid,
    input  tkm_pkg::item_t                q_item,
    output logic                          q_pop,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [tkm_pkg::TDATA_W-1:0]   m_axis_tdata,
    output logic                          m_axis_tlast
);

    localparam int IDX_W = $clog2(HEAD_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_PICK = 3'b100
    } state_t;

    state_t                        state_reg;
    logic [HEAD_DEPTH-1:0]         head_valid_reg;
    logic [HEAD_DEPTH-1:0]         finished_reg;
    logic [tkm_pkg::TS_W-1:0]      head_ts_reg    [HEAD_DEPTH];
    logic [tkm_pkg::DIR_W-1:0]     head_dir_reg   [HEAD_DEPTH];
    logic [HEAD_DEPTH-1:0]         head_known_reg;
    logic [tkm_pkg::TS_W-1:0]      last_ts_reg;
    tkm_pkg::cand_t                grp_reg [4];
    tkm_pkg::cand_t                grp_next [4];
    logic                          ready_reg;
    tkm_pkg::res_t                 pend_reg;
    logic                          pend_valid_reg;
    tkm_pkg::res_t                 out_reg;
    logic                          out_last_reg;
    logic                          out_valid_reg;

    tkm_pkg::cand_t                leaf [tkm_pkg::MAX_LANES];
    logic [HEAD_DEPTH-1:0]         lane_ok;
    logic                          ready_next;
    tkm_pkg::cand_t                win;
    logic [IDX_W-1:0]              win_idx;
    logic [IDX_W-1:0]              in_idx;
    logic                          out_free;
    logic                          have_pick;
    logic                          dup;
    logic                          take;
    logic                          flush;
    tkm_pkg::res_t                 res_next;
    logic [tkm_pkg::DIR_W-1:0]     raw_dir;
    logic                          raw_known;
    logic [tkm_pkg::DIR_W-1:0]     clamp_dir;
    logic [8:0]                    base_dir;
    logic [8:0]                    sum_dir;

    // Leaves of the minimum tree: only heads of lanes in use take part.
    for (genvar k = 0; k < tkm_pkg::MAX_LANES; k++)
    begin : g_leaf
        if (k < HEAD_DEPTH)
        begin : g_used
            logic in_use;
            assign in_use     = (tkm_pkg::CNT_W'(k) < cfg.lane_count);
            assign leaf[k]    = '{valid: head_valid_reg[k] && in_use,
                                  lane:  tkm_pkg::LANE_W'(k),
                                  ts:    head_ts_reg[k]};
            assign lane_ok[k] = head_valid_reg[k] || finished_reg[k] || !in_use;
        end
        else
        begin : g_pad
            assign leaf[k] = '0;
        end
    end

    assign ready_next = &lane_ok;

    always_comb
    begin
        for (int g = 0; g < 4; g++)
        begin
            grp_next[g] = tkm_pkg::cand_min(
                tkm_pkg::cand_min(leaf[4*g], leaf[4*g+1]),
                tkm_pkg::cand_min(leaf[4*g+2], leaf[4*g+3]));
        end
    end

    assign win = tkm_pkg::cand_min(tkm_pkg::cand_min(grp_reg[0], grp_reg[1]),
                                   tkm_pkg::cand_min(grp_reg[2], grp_reg[3]));
    assign win_idx = win.lane[IDX_W-1:0];
    assign in_idx  = q_item.lane[IDX_W-1:0];

    // Direction remap of the winning head.
    assign raw_dir   = head_dir_reg[win_idx];
    assign raw_known = head_known_reg[win_idx];
    assign clamp_dir = (raw_dir > tkm_pkg::DIR_W'(cfg.slots - 1'b1))
                       ? tkm_pkg::DIR_W'(cfg.slots - 1'b1) : raw_dir;
    assign base_dir  = {5'd0, win.lane} * {4'd0, cfg.slots};
    assign sum_dir   = base_dir + {1'b0, clamp_dir};

    always_comb
    begin
        res_next.lane  = win.lane;
        res_next.ts    = win.ts;
        res_next.known = raw_known;
        if (!raw_known)
        begin
            res_next.dir = '0;
        end
        else if (cfg.slots == '0)
        begin
            res_next.dir = raw_dir;
        end
        else
        begin
            res_next.dir = sum_dir[7:0];
        end
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign have_pick = (state_reg == ST_PICK) && ready_reg && win.valid;
    assign dup       = cfg.dedup && (win.ts == last_ts_reg);
    // A result is held back until the next one or the end of the run shows
    // whether it is the last one of its item.
    assign take      = have_pick && !dup && (!pend_valid_reg || out_free);
    assign flush     = (state_reg == ST_PICK) && !(ready_reg && win.valid)
                       && pend_valid_reg && out_free;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_ff @(posedge clk)
    begin
        if (q_pop && q_item.in_use && !q_item.is_end && !head_valid_reg[in_idx]
            && !finished_reg[in_idx])
        begin
            head_ts_reg[in_idx]    <= q_item.ts;
            head_dir_reg[in_idx]   <= q_item.dir;
            head_known_reg[in_idx] <= q_item.known;
        end
        if (state_reg == ST_SCAN)
        begin
            grp_reg <= grp_next;
        end
        if (take)
        begin
            pend_reg <= res_next;
        end
        if (take && pend_valid_reg)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b0;
        end
        else if (flush)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_valid_reg <= '0;
            finished_reg   <= '0;
            last_ts_reg    <= '0;
            ready_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((take && pend_valid_reg) || flush)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.in_use)
                        begin
                            if (q_item.is_end)
                            begin
                                finished_reg[in_idx] <= 1'b1;
                            end
                            else if (!head_valid_reg[in_idx] && !finished_reg[in_idx])
                            begin
                                head_valid_reg[in_idx] <= 1'b1;
                            end
                        end
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    ready_reg <= ready_next;
                    state_reg <= ST_PICK;
                end
                ST_PICK:
                begin
                    if (have_pick)
                    begin
                        if (dup)
                        begin
                            head_valid_reg[win_idx] <= 1'b0;
                            state_reg               <= ST_SCAN;
                        end
                        else if (take)
                        begin
                            head_valid_reg[win_idx] <= 1'b0;
                            pend_valid_reg          <= 1'b1;
                            last_ts_reg             <= win.ts;
                            state_reg               <= ST_SCAN;
                        end
                    end
                    else if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (flush)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {3'b000, out_reg.known, out_reg.dir, out_reg.ts, out_reg.lane};

endmodule

// ===== design/timestamp_kway_merge_core.sv =====
// Top level of the timestamp k-way merge: configuration registers, front end, queue and merge engine.
//
//  Channel   Direction  Handshake                 Contents
//  s_axis    in         s_axis_tvalid/tready      tdata: lane, timestamp, direction, known
//                                                 tuser: command (0 head, 1 end of lane)
//  m_axis    out        m_axis_tvalid/tready      tdata: lane, timestamp, direction, known
//                                                 tlast: final result of an input item
//  cfg       in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// The merge engine takes one queued item per pass: it updates the lane heads,
// then for each emitted or dropped head runs a registered 16-to-4 stage of the
// minimum tree, then the 4-to-1 stage and the remap. Each result is held one
// pick back so tlast can be set, and leaves through an output register; a
// stalled output holds the engine while the input queue keeps accepting until
// it is full. Reset clears all heads and lane flags.
module timestamp_kway_merge_core #(
    parameter int NUM_LANES   = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [3:0] lane, [67:4] timestamp, [75:68] direction, [76] direction_known
    input  logic [tkm_pkg::TDATA_W-1:0]      s_axis_tdata,
    // [0] command
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [3:0] out_lane, [67:4] out_timestamp, [75:68] out_direction,
    // [76] out_direction_known
    output logic [tkm_pkg::TDATA_W-1:0]      m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tkm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tkm_pkg::CNT_W-1:0]        cfg_data
);

    localparam int HEAD_DEPTH = (NUM_LANES < tkm_pkg::MAX_LANES) ? NUM_LANES
                                                                 : tkm_pkg::MAX_LANES;

    logic [tkm_pkg::CNT_W-1:0] lanes_in_use_reg;
    logic [tkm_pkg::CNT_W-1:0] lanes_per_input_reg;
    logic                      dedup_enable_reg;
    tkm_pkg::cfg_t             cfg;
    logic                      q_push;
    tkm_pkg::item_t            q_push_item;
    logic                      q_full;
    logic                      q_pop;
    tkm_pkg::item_t            q_pop_item;
    logic                      q_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lanes_in_use_reg    <= tkm_pkg::CNT_W'(2);
            lanes_per_input_reg <= '0;
            dedup_enable_reg    <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                tkm_pkg::CFG_LANES_IN_USE:    lanes_in_use_reg    <= cfg_data;
                tkm_pkg::CFG_LANES_PER_INPUT: lanes_per_input_reg <= cfg_data;
                tkm_pkg::CFG_DEDUP_ENABLE:    dedup_enable_reg    <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        if (lanes_in_use_reg == '0)
        begin
            cfg.lane_count = tkm_pkg::CNT_W'(1);
        end
        else if (lanes_in_use_reg > tkm_pkg::CNT_W'(HEAD_DEPTH))
        begin
            cfg.lane_count = tkm_pkg::CNT_W'(HEAD_DEPTH);
        end
        else
        begin
            cfg.lane_count = lanes_in_use_reg;
        end
        cfg.slots = (lanes_per_input_reg > tkm_pkg::CNT_W'(tkm_pkg::MAX_LANES))
                    ? tkm_pkg::CNT_W'(tkm_pkg::MAX_LANES) : lanes_per_input_reg;
        cfg.dedup = dedup_enable_reg;
    end

    tkm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg),
        .queue_full    (q_full),
        .push          (q_push),
        .push_item     (q_push_item)
    );

    tkm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .not_empty (q_valid)
    );

    tkm_back #(
        .HEAD_DEPTH (HEAD_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .q_valid       (q_valid),
        .q_item        (q_pop_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
